@@ rtl/imf_pkg.sv @@
// Shared types and constants for the image median filter.
`default_nettype none

package imf_pkg;

    localparam int K_MAX_KERNEL = 7;
    localparam int K_MAX_WIDTH  = 1024;
    localparam int K_CHANNELS   = 3;

    localparam int KS_W      = 3;
    localparam int IW_W      = 11;
    localparam int IH_W      = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [KS_W-1:0] RST_KERNEL = 3'd3;
    localparam logic [IW_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [IH_W-1:0] RST_HEIGHT = 12'd480;

    localparam int Q_DEPTH = 4;

    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic       cmd;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out0;
        logic [7:0] out1;
        logic [7:0] out2;
        logic       frame_end;
    } t_out_req;

    typedef struct packed {
        logic inner;
        logic frame_end;
    } t_emit_flags;

endpackage

`default_nettype wire

@@ rtl/imf_queue.sv @@
// Short request queue between the front and back parts of the filter.
`default_nettype none

module imf_queue import imf_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [DW-1:0]              i_data,
    input  wire logic                       i_pop,
    output logic      [DW-1:0]              o_data,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int IW = $clog2(DEPTH);

    logic [DW-1:0]              r_mem [DEPTH];
    logic [IW-1:0]              r_wr;
    logic [IW-1:0]              r_rd;
    logic [$clog2(DEPTH+1)-1:0] r_count;
    logic [IW-1:0]              n_wr;
    logic [IW-1:0]              n_rd;

    always_comb begin
        n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + 1'b1;
        n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ rtl/imf_front.sv @@
// Front part: configuration, line stores, position tracking and window column fetch.
`default_nettype none

module imf_front import imf_pkg::*; #(
    parameter int MAX_KERNEL = K_MAX_KERNEL,
    parameter int MAX_WIDTH  = K_MAX_WIDTH,
    parameter int NCH        = 3
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                 i_cfg_idx,
    input  wire logic [CFG_W-1:0]                     i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire t_in_req                              i_in_data,
    input  wire logic [$clog2(Q_DEPTH+1)-1:0]         i_q_count,
    output logic                                      o_push,
    output logic      [MAX_KERNEL*NCH*8-1:0]          o_col,
    output logic      [NCH*8-1:0]                     o_center,
    output t_emit_flags                               o_flags,
    output logic      [$clog2(MAX_KERNEL+1)-1:0]      o_k
);

    localparam int SW  = $clog2(MAX_KERNEL);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int PW  = $clog2((MAX_KERNEL / 2) * MAX_WIDTH + MAX_KERNEL / 2 + 2);
    localparam int PXW = NCH * 8;

    logic [KS_W-1:0] r_kernel;
    logic [IW_W-1:0] r_width;
    logic [IH_W-1:0] r_height;

    logic [CW-1:0]   r_in_col;
    logic [SW-1:0]   r_in_slot;
    logic [CW-1:0]   r_out_col;
    logic [SW-1:0]   r_out_slot;
    logic [IH_W-1:0] r_out_row;
    logic [PW-1:0]   r_pending;

    logic [KW-1:0]   k_sat;
    logic [KW-1:0]   eff_k;
    logic [KW-1:0]   half;
    logic [WW-1:0]   eff_w;
    logic [IH_W-1:0] eff_h;
    logic [PW-1:0]   lag;

    logic            accept;
    logic            is_drain;
    logic            emit;
    logic            wr_en;
    logic [PXW-1:0]  wr_pix;
    logic [23:0]     in_pix;
    logic            inner;
    logic            frame_end;
    logic            rd_wrap;
    logic [CW-1:0]   rd_col;
    logic [SW-1:0]   start_slot;

    logic [CW-1:0]   n_in_col;
    logic [SW-1:0]   n_in_slot;
    logic [CW-1:0]   n_out_col;
    logic [SW-1:0]   n_out_slot;
    logic [IH_W-1:0] n_out_row;
    logic [PW-1:0]   n_pending;

    logic            r_f2_valid;
    logic [SW-1:0]   r_f2_start;
    logic [SW-1:0]   r_f2_cslot;
    t_emit_flags     r_f2_flags;

    logic [PXW-1:0]  rd_a [MAX_KERNEL];
    logic [PXW-1:0]  rd_b [MAX_KERNEL];

    // effective window, width and height
    always_comb begin
        if (r_kernel == '0) begin
            k_sat = KW'(1);
        end else if (32'(r_kernel) > MAX_KERNEL) begin
            k_sat = KW'(MAX_KERNEL);
        end else begin
            k_sat = KW'(r_kernel);
        end
        eff_k = k_sat[0] ? k_sat : k_sat - 1'b1;
        half  = eff_k >> 1;
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        eff_h = (r_height == '0) ? IH_W'(1) : r_height;
        lag   = PW'(32'(half) * 32'(eff_w) + 32'(half));
    end

    assign o_k        = eff_k;
    assign o_in_stall = (32'(i_q_count) + 32'(r_f2_valid)) >= Q_DEPTH;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_drain   = (i_in_data.cmd == CMD_DRAIN);
    assign wr_en      = accept && !is_drain;
    assign in_pix     = {i_in_data.chan2, i_in_data.chan1, i_in_data.chan0};
    assign wr_pix     = in_pix[PXW-1:0];

    always_comb begin
        if (is_drain) begin
            emit = accept && (r_pending != '0);
        end else begin
            emit = accept && ((32'(r_pending) + 1) > 32'(lag));
        end
    end

    // classify the result position and work out the column to fetch
    always_comb begin
        int s;
        inner = (32'(r_out_row) >= 32'(half))
             && (32'(r_out_row) + 32'(half) < 32'(eff_h))
             && (32'(r_out_col) >= 32'(half))
             && (32'(r_out_col) + 32'(half) < 32'(eff_w));
        frame_end = (32'(r_out_row) == 32'(eff_h) - 1) && (32'(r_out_col) == 32'(eff_w) - 1);
        rd_wrap   = (32'(r_out_col) + 32'(half)) >= 32'(eff_w);
        rd_col    = rd_wrap ? CW'(32'(r_out_col) + 32'(half) - 32'(eff_w))
                            : CW'(32'(r_out_col) + 32'(half));
        s = 32'(r_out_slot) + 32'(rd_wrap) + MAX_KERNEL - 32'(half);
        if (s >= MAX_KERNEL) begin
            s = s - MAX_KERNEL;
        end
        if (s >= MAX_KERNEL) begin
            s = s - MAX_KERNEL;
        end
        start_slot = SW'(s);
    end

    // next positions
    always_comb begin
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_slot = r_out_slot;
        n_out_row  = r_out_row;
        n_pending  = r_pending;
        if (wr_en) begin
            if (32'(r_in_col) + 1 >= 32'(eff_w)) begin
                n_in_col  = '0;
                n_in_slot = (32'(r_in_slot) == MAX_KERNEL - 1) ? '0 : r_in_slot + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        if (emit) begin
            if (32'(r_out_col) + 1 >= 32'(eff_w)) begin
                n_out_col  = '0;
                n_out_slot = (32'(r_out_slot) == MAX_KERNEL - 1) ? '0 : r_out_slot + 1'b1;
                n_out_row  = (32'(r_out_row) + 1 >= 32'(eff_h)) ? '0 : r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (wr_en && !emit) begin
            n_pending = r_pending + 1'b1;
        end else if (accept && is_drain && emit) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel   <= RST_KERNEL;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_out_row  <= '0;
            r_pending  <= '0;
            r_f2_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KERNEL: begin
                    r_kernel <= i_cfg_data[KS_W-1:0];
                end
                REG_WIDTH: begin
                    r_width <= i_cfg_data[IW_W-1:0];
                end
                REG_HEIGHT: begin
                    r_height <= i_cfg_data[IH_W-1:0];
                end
                default: begin
                end
            endcase
            // restart the stream on any known register
            if (t_reg_idx'(i_cfg_idx) == REG_KERNEL || t_reg_idx'(i_cfg_idx) == REG_WIDTH
                    || t_reg_idx'(i_cfg_idx) == REG_HEIGHT) begin
                r_in_col   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_slot <= '0;
                r_out_row  <= '0;
                r_pending  <= '0;
            end
            r_f2_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_slot <= n_out_slot;
            r_out_row  <= n_out_row;
            r_pending  <= n_pending;
            r_f2_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_f2_start           <= start_slot;
            r_f2_cslot           <= r_out_slot;
            r_f2_flags.inner     <= inner;
            r_f2_flags.frame_end <= frame_end;
        end
    end

    // one line store per slot: one write port, two registered read ports
    for (genvar gb = 0; gb < MAX_KERNEL; gb++) begin : g_bank
        logic [PXW-1:0] r_mem [MAX_WIDTH];
        logic [PXW-1:0] r_a;
        logic [PXW-1:0] r_b;
        logic           hit;

        assign hit = wr_en && (32'(r_in_slot) == gb);

        always_ff @(posedge i_clk) begin
            if (hit) begin
                r_mem[r_in_col] <= wr_pix;
            end
        end

        // pass the pixel written in the same cycle straight through
        always_ff @(posedge i_clk) begin
            if (emit) begin
                r_a <= (hit && r_in_col == rd_col)    ? wr_pix : r_mem[rd_col];
                r_b <= (hit && r_in_col == r_out_col) ? wr_pix : r_mem[r_out_col];
            end
        end

        assign rd_a[gb] = r_a;
        assign rd_b[gb] = r_b;
    end

    // rotate the fetched column so that the top window row comes first
    always_comb begin
        int idx;
        for (int dy = 0; dy < MAX_KERNEL; dy++) begin
            idx = 32'(r_f2_start) + dy;
            if (idx >= MAX_KERNEL) begin
                idx = idx - MAX_KERNEL;
            end
            o_col[dy*PXW +: PXW] = rd_a[SW'(idx)];
        end
    end

    assign o_center = rd_b[r_f2_cslot];
    assign o_flags  = r_f2_flags;
    assign o_push   = r_f2_valid;

endmodule

`default_nettype wire

@@ rtl/imf_back.sv @@
// Back part: sliding window, rank-based median per channel and output register.
`default_nettype none

module imf_back import imf_pkg::*; #(
    parameter int MAX_KERNEL = K_MAX_KERNEL,
    parameter int NCH        = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [$clog2(MAX_KERNEL+1)-1:0] i_k,
    input  wire logic                            i_q_nonempty,
    output logic                                 o_q_pop,
    input  wire logic [MAX_KERNEL*NCH*8-1:0]     i_q_col,
    input  wire logic [NCH*8-1:0]                i_q_center,
    input  wire t_emit_flags                     i_q_flags,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output t_out_req                             o_out_data
);

    localparam int PXW = NCH * 8;
    localparam int N   = MAX_KERNEL * MAX_KERNEL;
    localparam int RKW = $clog2(N);

    logic [PXW-1:0] r_win [MAX_KERNEL][MAX_KERNEL];
    logic           adv;

    logic           r_s1_valid;
    logic [PXW-1:0] r_s1_center;
    t_emit_flags    r_s1_flags;

    logic           r_s2_valid;
    logic [PXW-1:0] r_s2_center;
    t_emit_flags    r_s2_flags;
    logic [N-1:0]   r_act;

    logic           r_out_valid;
    t_out_req       r_out_data;

    logic [N-1:0]   act;
    logic [RKW-1:0] target;
    logic [7:0]     med  [NCH];
    logic [7:0]     chan [3];
    t_out_req       n_out_data;

    // hold everything while a finished result waits
    assign adv     = !r_out_valid || !i_out_stall;
    assign o_q_pop = adv && i_q_nonempty;

    // the newest k columns and the top k rows form the window
    always_comb begin
        for (int e = 0; e < N; e++) begin
            act[e] = ((e / MAX_KERNEL) >= (MAX_KERNEL - 32'(i_k)))
                  && ((e % MAX_KERNEL) < 32'(i_k));
        end
        target = RKW'((32'(i_k) * 32'(i_k)) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_q_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_q_pop) begin
                for (int x = 0; x < MAX_KERNEL - 1; x++) begin
                    for (int y = 0; y < MAX_KERNEL; y++) begin
                        r_win[x][y] <= r_win[x+1][y];
                    end
                end
                for (int y = 0; y < MAX_KERNEL; y++) begin
                    r_win[MAX_KERNEL-1][y] <= i_q_col[y*PXW +: PXW];
                end
                r_s1_center <= i_q_center;
                r_s1_flags  <= i_q_flags;
            end
            r_s2_center <= r_s1_center;
            r_s2_flags  <= r_s1_flags;
            r_act       <= act;
            r_out_data  <= n_out_data;
        end
    end

    for (genvar gc = 0; gc < NCH; gc++) begin : g_chan
        logic [7:0]     vals   [N];
        logic [RKW-1:0] rank   [N];
        logic [7:0]     r_val  [N];
        logic [RKW-1:0] r_rank [N];

        // rank of each element, ties broken by position
        always_comb begin
            logic [N-1:0] below;
            for (int e = 0; e < N; e++) begin
                vals[e] = r_win[e / MAX_KERNEL][e % MAX_KERNEL][gc*8 +: 8];
            end
            for (int i = 0; i < N; i++) begin
                for (int j = 0; j < N; j++) begin
                    below[j] = act[j]
                            && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
                end
                rank[i] = RKW'($countones(below));
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int e = 0; e < N; e++) begin
                    r_val[e]  <= vals[e];
                    r_rank[e] <= rank[e];
                end
            end
        end

        always_comb begin
            med[gc] = '0;
            for (int e = 0; e < N; e++) begin
                if (r_act[e] && r_rank[e] == target) begin
                    med[gc] = med[gc] | r_val[e];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            chan[c] = '0;
        end
        for (int c = 0; c < NCH; c++) begin
            chan[c] = r_s2_flags.inner ? med[c] : r_s2_center[c*8 +: 8];
        end
        n_out_data.out0      = chan[0];
        n_out_data.out1      = chan[1];
        n_out_data.out2      = chan[2];
        n_out_data.frame_end = r_s2_flags.frame_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ rtl/image_median_filter.sv @@
// Throughput: one request per cycle while o_in_stall is low.
// The 4-entry queue between fetch and median absorbs stalls.
// Each result needs one column fetch from every line store bank in a single cycle.
// Reset (synchronous, active low): positions and counts clear, registers return to 3/640/480.
// The line stores are not cleared; they hold no valid data until written.
`default_nettype none

module image_median_filter import imf_pkg::*; #(
    parameter int MAX_KERNEL = K_MAX_KERNEL,
    parameter int MAX_WIDTH  = K_MAX_WIDTH,
    parameter int CHANNELS   = K_CHANNELS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_req              i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_req                  o_out_data
);

    localparam int NCH  = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int PXW  = NCH * 8;
    localparam int COLW = MAX_KERNEL * PXW;
    localparam int FW   = $bits(t_emit_flags);
    localparam int QDW  = COLW + PXW + FW;
    localparam int KW   = $clog2(MAX_KERNEL + 1);

    logic                         push;
    logic [COLW-1:0]              f_col;
    logic [PXW-1:0]               f_center;
    t_emit_flags                  f_flags;
    logic [KW-1:0]                eff_k;
    logic                         pop;
    logic [QDW-1:0]               q_out;
    logic [$clog2(Q_DEPTH+1)-1:0] q_count;

    imf_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .NCH        (NCH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_col      (f_col),
        .o_center   (f_center),
        .o_flags    (f_flags),
        .o_k        (eff_k)
    );

    imf_queue #(
        .DW    (QDW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_col, f_center, f_flags}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_count (q_count)
    );

    imf_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .NCH        (NCH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_k          (eff_k),
        .i_q_nonempty (q_count != '0),
        .o_q_pop      (pop),
        .i_q_col      (q_out[QDW-1 -: COLW]),
        .i_q_center   (q_out[FW +: PXW]),
        .i_q_flags    (t_emit_flags'(q_out[FW-1:0])),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
